// ===== hw/rtl/crcm_pkg.sv =====
package crcm_pkg;

  // Grid and field geometry.
  localparam int NDIMS      = 4;
  localparam int DIDX_W     = 2;
  localparam int NCNT_W     = 3;
  localparam int RANK_W     = 20;
  localparam int EXT_W      = 21;
  localparam int COORD_W    = 22;
  localparam int DISPL_W    = 21;
  localparam int DIR_W      = 3;
  localparam int PMASK_W    = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int LANES      = NDIMS + 1;

  // Pipelined divider geometry: DIV_BITS quotient bits are resolved per stage.
  localparam int DIV_W      = 24;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = DIV_W / DIV_BITS;

  // Stream widths.
  localparam int IN_TDATA_W  = 136;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 152;

  typedef enum logic [1:0] {
    OP_SPLIT = 2'd0,
    OP_FOLD  = 2'd1,
    OP_SHIFT = 2'd2,
    OP_RSVD  = 2'd3
  } crcm_op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_BADARG = 2'd2
  } crcm_status_t;

  typedef enum logic [2:0] {
    CFG_NUM_DIMS   = 3'd0,
    CFG_DIM_SIZE_0 = 3'd1,
    CFG_DIM_SIZE_1 = 3'd2,
    CFG_DIM_SIZE_2 = 3'd3,
    CFG_DIM_SIZE_3 = 3'd4,
    CFG_PERIODIC   = 3'd5,
    CFG_NODE_COUNT = 3'd6
  } crcm_cfg_idx_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_LOAD,
    SEQ_DIV,
    SEQ_MUL
  } crcm_seq_state_t;

  // One stage of the restoring divider: partial remainder, the dividend
  // shifting out at the top while quotient bits shift in at the bottom.
  typedef struct packed {
    logic [EXT_W-1:0] rem;
    logic [DIV_W-1:0] word;
    logic [EXT_W-1:0] dvs;
  } crcm_div_t;

endpackage

// ===== hw/rtl/crcm_div_pipe.sv =====
module crcm_div_pipe (
  input  logic                        clk,
  input  logic                        en,
  input  logic [crcm_pkg::DIV_W-1:0]  dvd,
  input  logic [crcm_pkg::EXT_W-1:0]  dvs,
  output logic [crcm_pkg::DIV_W-1:0]  quo,
  output logic [crcm_pkg::EXT_W-1:0]  rem
);

  crcm_pkg::crcm_div_t st_r   [crcm_pkg::DIV_STAGES];
  crcm_pkg::crcm_div_t st_nxt [crcm_pkg::DIV_STAGES];

  // Each stage resolves DIV_BITS quotient bits by compare and subtract.
  for (genvar s = 0; s < crcm_pkg::DIV_STAGES; s++) begin : g_stage
    always_comb begin
      crcm_pkg::crcm_div_t cur;
      logic [crcm_pkg::EXT_W:0] t;
      if (s == 0) begin
        cur.rem  = '0;
        cur.word = dvd;
        cur.dvs  = dvs;
      end else begin
        cur = st_r[s-1];
      end
      for (int k = 0; k < crcm_pkg::DIV_BITS; k++) begin
        t = {cur.rem, cur.word[crcm_pkg::DIV_W-1]};
        cur.word = {cur.word[crcm_pkg::DIV_W-2:0], 1'b0};
        if (t >= {1'b0, cur.dvs}) begin
          t = t - {1'b0, cur.dvs};
          cur.word[0] = 1'b1;
        end
        cur.rem = t[crcm_pkg::EXT_W-1:0];
      end
      st_nxt[s] = cur;
    end
  end

  // The whole chain holds while the pipeline is stalled.
  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign quo = st_r[crcm_pkg::DIV_STAGES-1].word;
  assign rem = st_r[crcm_pkg::DIV_STAGES-1].rem;

endmodule

// ===== hw/rtl/cartesian_rank_coordinate_map_unit.sv =====
// Converts between a linear rank and coordinates on a grid of up to four
// dimensions. Each transaction gives exactly one result transaction. The block
// accepts one transaction per clock unless the output stalls or a table pass
// runs. Its pipeline holds four chained six-stage dividers that split the rank,
// one more six-stage divider per lane for the periodic wrap, and the multiply
// and sum stages of the fold. Any configuration write starts a pass that
// recomputes the per-dimension span and stride tables with a serial divider
// and multiplier; in_tready stays low during that pass.
module cartesian_rank_coordinate_map_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // rank_in, coord_in_0, coord_in_1, coord_in_2, coord_in_3, direction,
  // displacement, zero fill
  input  logic [crcm_pkg::IN_TDATA_W-1:0]      in_tdata,
  // op
  input  logic [crcm_pkg::IN_TUSER_W-1:0]      in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // status, rank_out, rank_null, coord_out_0, coord_out_1, coord_out_2,
  // coord_out_3, source_rank, source_null, dest_rank, dest_null, zero fill
  output logic [crcm_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_wr_en,
  input  logic [crcm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [crcm_pkg::EXT_W-1:0]           cfg_wr_data
);

  localparam int NDIMS   = crcm_pkg::NDIMS;
  localparam int LANES   = crcm_pkg::LANES;
  localparam int RANK_W  = crcm_pkg::RANK_W;
  localparam int EXT_W   = crcm_pkg::EXT_W;
  localparam int COORD_W = crcm_pkg::COORD_W;
  localparam int DIV_W   = crcm_pkg::DIV_W;
  localparam int DSTG    = crcm_pkg::DIV_STAGES;
  localparam int NCNT_W  = crcm_pkg::NCNT_W;
  localparam int DIDX_W  = crcm_pkg::DIDX_W;

  typedef struct packed {
    crcm_pkg::crcm_op_t                     op;
    logic [RANK_W-1:0]                      rank;
    logic [NDIMS-1:0][COORD_W-1:0]          cin;
    logic [crcm_pkg::DIR_W-1:0]             dir;
    logic [crcm_pkg::DISPL_W-1:0]           displ;
    logic [NDIMS-1:0][RANK_W-1:0]           c;
  } spl_t;

  typedef struct packed {
    crcm_pkg::crcm_op_t                     op;
    logic                                   bad;
    logic [NDIMS-1:0][RANK_W-1:0]           c;
    logic [DIDX_W-1:0]                      dir;
    logic [LANES-1:0][COORD_W-1:0]          v;
    logic [LANES-1:0][EXT_W-1:0]            ext;
    logic [LANES-1:0]                       per;
  } lan_t;

  typedef struct packed {
    crcm_pkg::crcm_op_t                     op;
    logic                                   bad;
    logic [NDIMS-1:0][RANK_W-1:0]           c;
    logic [DIDX_W-1:0]                      dir;
    logic [LANES-1:0][RANK_W-1:0]           prod;
    logic [LANES-1:0]                       oor;
  } prd_t;

  // Configuration registers and derived tables.
  logic [NCNT_W-1:0]             num_dims_r;
  logic [EXT_W-1:0]              ext_r    [NDIMS];
  logic [crcm_pkg::PMASK_W-1:0]  pmask_r;
  logic [EXT_W-1:0]              ncount_r;
  logic [EXT_W-1:0]              span_r   [NDIMS];
  logic [RANK_W-1:0]             mult_r   [NDIMS];
  logic [NCNT_W-1:0]             ndim;

  // Table sequencer.
  crcm_pkg::crcm_seq_state_t     seq_state_r, seq_state_nxt;
  logic [DIDX_W-1:0]             seq_dim_r;
  logic [4:0]                    seq_cnt_r;
  logic [EXT_W-1:0]              seq_dvd_r, seq_rem_r, seq_quo_r;
  logic [EXT_W-1:0]              seq_prev, seq_rem_nxt, seq_span_new;
  logic [EXT_W:0]                seq_t;
  logic                          seq_qbit;
  logic [NCNT_W-1:0]             seq_nidx;
  logic [RANK_W+EXT_W-1:0]       seq_prod;
  logic [RANK_W-1:0]             seq_mult_new;

  // Pipeline.
  logic                          adv, in_fire;
  spl_t                          p0_r;
  logic                          v0_r;
  spl_t                          pin [NDIMS+1];
  logic                          vin [NDIMS+1];
  lan_t                          lan_nxt, lanl_r;
  logic                          vl_r;
  lan_t                          lan_r [DSTG];
  logic                          lv_r  [DSTG];
  logic [EXT_W-1:0]              mrem  [LANES];
  prd_t                          prd_nxt, prd_r;
  logic                          vp_r;
  logic [crcm_pkg::OUT_TDATA_W-1:0] out_nxt, out_tdata_r;
  logic                          out_valid_r;

  assign ndim = (num_dims_r > NCNT_W'(NDIMS)) ? NCNT_W'(NDIMS) : num_dims_r;

  // Sequencer next state: a configuration write always restarts the pass.
  always_comb begin
    seq_state_nxt = seq_state_r;
    unique case (seq_state_r)
      crcm_pkg::SEQ_IDLE: seq_state_nxt = crcm_pkg::SEQ_IDLE;
      crcm_pkg::SEQ_LOAD: seq_state_nxt = crcm_pkg::SEQ_DIV;
      crcm_pkg::SEQ_DIV: begin
        if (seq_cnt_r == 5'(EXT_W - 1)) begin
          seq_state_nxt = (seq_dim_r == DIDX_W'(NDIMS - 1)) ?
                          crcm_pkg::SEQ_MUL : crcm_pkg::SEQ_LOAD;
        end
      end
      crcm_pkg::SEQ_MUL: begin
        if (seq_dim_r == '0) begin
          seq_state_nxt = crcm_pkg::SEQ_IDLE;
        end
      end
      default: seq_state_nxt = crcm_pkg::SEQ_IDLE;
    endcase
    if (cfg_wr_en) begin
      seq_state_nxt = crcm_pkg::SEQ_LOAD;
    end
  end

  // Sequencer datapath: one divide step or one stride product per cycle.
  always_comb begin
    seq_prev     = (seq_dim_r == '0) ? ncount_r : span_r[seq_dim_r - 2'd1];
    seq_t        = {seq_rem_r, seq_dvd_r[EXT_W-1]};
    seq_qbit     = (seq_t >= {1'b0, ext_r[seq_dim_r]});
    seq_rem_nxt  = seq_qbit ? EXT_W'(seq_t - {1'b0, ext_r[seq_dim_r]}) :
                              seq_t[EXT_W-1:0];
    seq_span_new = (ext_r[seq_dim_r] == '0) ? '0 :
                   {seq_quo_r[EXT_W-2:0], seq_qbit};
    seq_nidx     = {1'b0, seq_dim_r} + NCNT_W'(1);
    seq_prod     = mult_r[seq_dim_r + 2'd1] * ext_r[seq_dim_r + 2'd1];
    seq_mult_new = (seq_nidx >= ndim) ? RANK_W'(1) : seq_prod[RANK_W-1:0];
  end

  // Configuration registers, tables and sequencer control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_state_r <= crcm_pkg::SEQ_IDLE;
      seq_dim_r   <= '0;
      num_dims_r  <= NCNT_W'(1);
      pmask_r     <= '0;
      ncount_r    <= EXT_W'(1);
      for (int i = 0; i < NDIMS; i++) begin
        ext_r[i]  <= EXT_W'(1);
        span_r[i] <= EXT_W'(1);
        mult_r[i] <= RANK_W'(1);
      end
    end else begin
      seq_state_r <= seq_state_nxt;
      unique case (seq_state_r)
        crcm_pkg::SEQ_DIV: begin
          if (seq_cnt_r == 5'(EXT_W - 1)) begin
            span_r[seq_dim_r] <= seq_span_new;
            if (seq_dim_r != DIDX_W'(NDIMS - 1)) begin
              seq_dim_r <= seq_dim_r + 2'd1;
            end
          end
        end
        crcm_pkg::SEQ_MUL: begin
          mult_r[seq_dim_r] <= seq_mult_new;
          seq_dim_r         <= seq_dim_r - 2'd1;
        end
        default: ;
      endcase
      if (cfg_wr_en) begin
        seq_dim_r <= '0;
        unique case (crcm_pkg::crcm_cfg_idx_t'(cfg_addr))
          crcm_pkg::CFG_NUM_DIMS:   num_dims_r <= cfg_wr_data[NCNT_W-1:0];
          crcm_pkg::CFG_DIM_SIZE_0: ext_r[0]   <= cfg_wr_data;
          crcm_pkg::CFG_DIM_SIZE_1: ext_r[1]   <= cfg_wr_data;
          crcm_pkg::CFG_DIM_SIZE_2: ext_r[2]   <= cfg_wr_data;
          crcm_pkg::CFG_DIM_SIZE_3: ext_r[3]   <= cfg_wr_data;
          crcm_pkg::CFG_PERIODIC:   pmask_r    <= cfg_wr_data[crcm_pkg::PMASK_W-1:0];
          crcm_pkg::CFG_NODE_COUNT: ncount_r   <= cfg_wr_data;
          default: ;
        endcase
      end
    end
  end

  // Serial divider working registers.
  always_ff @(posedge clk) begin
    if (seq_state_r == crcm_pkg::SEQ_LOAD) begin
      seq_dvd_r <= seq_prev;
      seq_rem_r <= '0;
      seq_quo_r <= '0;
      seq_cnt_r <= '0;
    end else if (seq_state_r == crcm_pkg::SEQ_DIV) begin
      seq_dvd_r <= {seq_dvd_r[EXT_W-2:0], 1'b0};
      seq_rem_r <= seq_rem_nxt;
      seq_quo_r <= {seq_quo_r[EXT_W-2:0], seq_qbit};
      seq_cnt_r <= seq_cnt_r + 5'd1;
    end
  end

  // Pipeline flow: every stage moves together when the output can move.
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv && (seq_state_r == crcm_pkg::SEQ_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // Input register.
  always_ff @(posedge clk) begin
    if (adv) begin
      p0_r.op     <= crcm_pkg::crcm_op_t'(in_tuser);
      p0_r.rank   <= in_tdata[19:0];
      p0_r.cin[0] <= in_tdata[41:20];
      p0_r.cin[1] <= in_tdata[63:42];
      p0_r.cin[2] <= in_tdata[85:64];
      p0_r.cin[3] <= in_tdata[107:86];
      p0_r.dir    <= in_tdata[110:108];
      p0_r.displ  <= in_tdata[131:111];
      p0_r.c      <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_fire;
    end
  end

  // Takes one coordinate from a divider result and carries the remainder on.
  function automatic spl_t spl_take(input spl_t s, input logic [DIV_W-1:0] q,
                                    input logic [EXT_W-1:0] r,
                                    input logic [EXT_W-1:0] span,
                                    input logic use_d, input logic [DIDX_W-1:0] idx);
    spl_t o;
    o = s;
    if (span != '0) begin
      o.rank = r[RANK_W-1:0];
      if (use_d) begin
        o.c[idx] = q[RANK_W-1:0];
      end
    end else begin
      o.rank = '0;
    end
    return o;
  endfunction

  assign pin[0] = p0_r;
  assign vin[0] = v0_r;

  // Rank split: one pipelined divider per dimension, most significant first.
  for (genvar d = 0; d < NDIMS; d++) begin : g_split
    spl_t             sd_r [DSTG];
    logic             sv_r [DSTG];
    logic [DIV_W-1:0] quo;
    logic [EXT_W-1:0] rem;

    crcm_div_pipe u_div (
      .clk (clk),
      .en  (adv),
      .dvd (DIV_W'(pin[d].rank)),
      .dvs (span_r[d]),
      .quo (quo),
      .rem (rem)
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        sd_r[0] <= pin[d];
        for (int k = 1; k < DSTG; k++) begin
          sd_r[k] <= sd_r[k-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        for (int k = 0; k < DSTG; k++) begin
          sv_r[k] <= 1'b0;
        end
      end else if (adv) begin
        sv_r[0] <= vin[d];
        for (int k = 1; k < DSTG; k++) begin
          sv_r[k] <= sv_r[k-1];
        end
      end
    end

    assign pin[d+1] = spl_take(sd_r[DSTG-1], quo, rem, span_r[d],
                               (ndim > NCNT_W'(d)), DIDX_W'(d));
    assign vin[d+1] = sv_r[DSTG-1];
  end

  // Lane setup: four dimension lanes plus a lane for the source coordinate.
  always_comb begin
    logic [COORD_W-1:0] dspx;
    logic [DIDX_W-1:0]  dr;
    dspx         = {pin[NDIMS].displ[crcm_pkg::DISPL_W-1], pin[NDIMS].displ};
    dr           = pin[NDIMS].dir[DIDX_W-1:0];
    lan_nxt.op   = pin[NDIMS].op;
    lan_nxt.c    = pin[NDIMS].c;
    lan_nxt.dir  = dr;
    lan_nxt.bad  = (pin[NDIMS].op == crcm_pkg::OP_RSVD) ||
                   ((pin[NDIMS].op == crcm_pkg::OP_SHIFT) &&
                    ((pin[NDIMS].dir >= ndim) || (pin[NDIMS].displ == '0)));
    for (int i = 0; i < NDIMS; i++) begin
      lan_nxt.ext[i] = ext_r[i];
      lan_nxt.per[i] = pmask_r[i];
      if (pin[NDIMS].op == crcm_pkg::OP_FOLD) begin
        lan_nxt.v[i] = pin[NDIMS].cin[i];
      end else if (pin[NDIMS].dir == crcm_pkg::DIR_W'(i)) begin
        lan_nxt.v[i] = COORD_W'(pin[NDIMS].c[i]) + dspx;
      end else begin
        lan_nxt.v[i] = COORD_W'(pin[NDIMS].c[i]);
      end
    end
    lan_nxt.ext[NDIMS] = ext_r[dr];
    lan_nxt.per[NDIMS] = pmask_r[dr];
    lan_nxt.v[NDIMS]   = COORD_W'(pin[NDIMS].c[dr]) - dspx;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lanl_r <= lan_nxt;
      lan_r[0] <= lanl_r;
      for (int k = 1; k < DSTG; k++) begin
        lan_r[k] <= lan_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r <= 1'b0;
      for (int k = 0; k < DSTG; k++) begin
        lv_r[k] <= 1'b0;
      end
    end else if (adv) begin
      vl_r     <= vin[NDIMS];
      lv_r[0]  <= vl_r;
      for (int k = 1; k < DSTG; k++) begin
        lv_r[k] <= lv_r[k-1];
      end
    end
  end

  // Periodic wrap: remainder of the coordinate magnitude by the extent.
  for (genvar l = 0; l < LANES; l++) begin : g_wrap
    logic [COORD_W-1:0] mag;
    assign mag = lanl_r.v[l][COORD_W-1] ? (-lanl_r.v[l]) : lanl_r.v[l];

    crcm_div_pipe u_mod (
      .clk (clk),
      .en  (adv),
      .dvd (DIV_W'(mag)),
      .dvs (lanl_r.ext[l]),
      .quo (),
      .rem (mrem[l])
    );
  end

  // Range check, true modulo fix-up and stride products.
  always_comb begin
    lan_t               s;
    logic [EXT_W-1:0]   w;
    logic [RANK_W-1:0]  m;
    logic [2*RANK_W-1:0] p;
    s            = lan_r[DSTG-1];
    prd_nxt.op   = s.op;
    prd_nxt.bad  = s.bad;
    prd_nxt.c    = s.c;
    prd_nxt.dir  = s.dir;
    for (int l = 0; l < LANES; l++) begin
      if (s.per[l]) begin
        prd_nxt.oor[l] = 1'b0;
        if (s.ext[l] == '0) begin
          w = '0;
        end else if (s.v[l][COORD_W-1] && (mrem[l] != '0)) begin
          w = s.ext[l] - mrem[l];
        end else begin
          w = mrem[l];
        end
      end else begin
        w = s.v[l][EXT_W-1:0];
        prd_nxt.oor[l] = s.v[l][COORD_W-1] || (s.v[l][EXT_W-1:0] >= s.ext[l]);
      end
      m = (l < NDIMS) ? mult_r[l] : mult_r[s.dir];
      p = m * w[RANK_W-1:0];
      prd_nxt.prod[l] = p[RANK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prd_r <= prd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else if (adv) begin
      vp_r <= lv_r[DSTG-1];
    end
  end

  // Rank sums for destination and source, then result formatting.
  always_comb begin
    logic [RANK_W-1:0]        dsum, ssum;
    logic                     dnull, snull;
    crcm_pkg::crcm_status_t   st;
    logic [RANK_W-1:0]        rank_out, src_rank, dst_rank;
    logic                     rank_null, src_null, dst_null;
    logic [NDIMS-1:0][RANK_W-1:0] co;
    dsum  = '0;
    ssum  = prd_r.prod[NDIMS];
    dnull = 1'b0;
    snull = prd_r.oor[NDIMS];
    for (int i = 0; i < NDIMS; i++) begin
      if (ndim > NCNT_W'(i)) begin
        dsum  = dsum + prd_r.prod[i];
        dnull = dnull | prd_r.oor[i];
        if (prd_r.dir != DIDX_W'(i)) begin
          ssum  = ssum + prd_r.prod[i];
          snull = snull | prd_r.oor[i];
        end
      end
    end
    st        = crcm_pkg::ST_OK;
    rank_out  = '0;
    rank_null = 1'b0;
    co        = '0;
    src_rank  = '0;
    src_null  = 1'b0;
    dst_rank  = '0;
    dst_null  = 1'b0;
    if (prd_r.bad) begin
      st = crcm_pkg::ST_BADARG;
    end else begin
      unique case (prd_r.op)
        crcm_pkg::OP_SPLIT: co = prd_r.c;
        crcm_pkg::OP_FOLD: begin
          if (dnull) begin
            st        = crcm_pkg::ST_RANGE;
            rank_null = 1'b1;
          end else begin
            rank_out = dsum;
          end
        end
        crcm_pkg::OP_SHIFT: begin
          dst_null = dnull;
          dst_rank = dnull ? '0 : dsum;
          src_null = snull;
          src_rank = snull ? '0 : ssum;
        end
        default: st = crcm_pkg::ST_BADARG;
      endcase
    end
    out_nxt = {7'd0, dst_null, dst_rank, src_null, src_rank,
               co[3], co[2], co[1], co[0], rank_null, rank_out, st};
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vp_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== hw/rtl/crcm_checker.sv =====
module crcm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [crcm_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic [crcm_pkg::IN_TUSER_W-1:0]   in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [crcm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                              cfg_wr_en,
  input logic [crcm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input logic [crcm_pkg::EXT_W-1:0]        cfg_wr_data
);

  // A stalled result transaction holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The status code never takes the unused value.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("unused status code");

  // A null fold rank reads as zero and reports an out-of-range coordinate.
  a_rank_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[22] |-> out_tdata[21:2] == 20'd0 &&
                                    out_tdata[1:0] == 2'd1)
    else $error("null rank without range status");

  // A bad argument clears every other result field.
  a_bad_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == 2'd2 |-> out_tdata[151:2] == '0)
    else $error("bad argument result carries data");

  // A configuration write blocks new transactions while tables rebuild.
  a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> !in_tready)
    else $error("input accepted during table rebuild");

endmodule

bind cartesian_rank_coordinate_map_unit crcm_checker u_crcm_checker (.*);

// ===== sim/tb_cartesian_rank_coordinate_map_unit.sv =====
`timescale 1ns / 100ps

module tb_cartesian_rank_coordinate_map_unit;
  import crcm_pkg::*;

  localparam int DRAIN_CYCLES = 48;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 1800;
  // Writes to this index land on no register.
  localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED = 3'd7;

  // Result transaction as the block packs it, last field in the low bits.
  typedef struct packed {
    logic                   dest_null;
    logic [RANK_W-1:0]      dest_rank;
    logic                   source_null;
    logic [RANK_W-1:0]      source_rank;
    logic [3:0][RANK_W-1:0] coord;
    logic                   rank_null;
    logic [RANK_W-1:0]      rank_out;
    crcm_status_t           status;
  } map_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [EXT_W-1:0]       cfg_wr_data = '0;

  // Shadow copy of the configuration registers.
  logic [2:0]       grid_dims;
  logic [EXT_W-1:0] grid_ext [4];
  logic [3:0]       grid_wrap;
  logic [EXT_W-1:0] grid_nodes;

  map_result_t pending_results[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          config_phases = 0;
  bit          no_idle = 1'b0;
  int          stall_left = 0;

  cartesian_rank_coordinate_map_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int used_dim_count();
    return (grid_dims > 3'd4) ? 4 : int'(grid_dims);
  endfunction

  // Successive division of a rank into coordinates, most significant first.
  function automatic void split_rank_to_coords(input longint unsigned rank,
                                               output longint c[4]);
    longint unsigned span;
    longint unsigned ext;
    int n;
    n = used_dim_count();
    span = grid_nodes;
    for (int d = 0; d < 4; d++) c[d] = 0;
    for (int d = 0; d < n; d++) begin
      ext = grid_ext[d];
      span = (ext != 0) ? span / ext : 0;
      if (span != 0) begin
        c[d] = longint'(rank / span);
        rank = rank % span;
      end else begin
        c[d] = 0;
        rank = 0;
      end
    end
  endfunction

  // Folds coordinates into a rank; returns 0 when a fixed edge is crossed.
  function automatic bit fold_coords_to_rank(input longint c[4],
                                             output logic [RANK_W-1:0] rank);
    longint unsigned mult;
    longint unsigned acc;
    longint ext;
    longint v;
    mult = 1;
    acc = 0;
    rank = '0;
    for (int i = used_dim_count() - 1; i >= 0; i--) begin
      ext = longint'(grid_ext[i]);
      v = c[i];
      if (grid_wrap[i]) begin
        if (ext == 0) begin
          v = 0;
        end else begin
          v = v % ext;
          if (v < 0) v = v + ext;
        end
      end else if (v < 0 || v >= ext) begin
        return 1'b0;
      end
      acc = acc + mult * longint'(v);
      mult = mult * longint'(ext);
    end
    rank = acc[RANK_W-1:0];
    return 1'b1;
  endfunction

  function automatic map_result_t predict_mapping(crcm_op_t op, logic [RANK_W-1:0] rank,
                                                  logic signed [COORD_W-1:0] cin[4],
                                                  logic [DIR_W-1:0] dir,
                                                  logic signed [DISPL_W-1:0] displ);
    map_result_t r;
    longint c[4];
    logic [RANK_W-1:0] folded;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_SPLIT: begin
        split_rank_to_coords(rank, c);
        for (int d = 0; d < 4; d++) r.coord[d] = c[d][RANK_W-1:0];
      end
      OP_FOLD: begin
        for (int d = 0; d < 4; d++) c[d] = longint'(cin[d]);
        if (fold_coords_to_rank(c, folded)) begin
          r.rank_out = folded;
        end else begin
          r.status = ST_RANGE;
          r.rank_null = 1'b1;
        end
      end
      OP_SHIFT: begin
        if (int'(dir) >= used_dim_count() || displ == 0) begin
          r.status = ST_BADARG;
        end else begin
          split_rank_to_coords(rank, c);
          c[dir] = c[dir] + longint'(displ);
          if (fold_coords_to_rank(c, folded)) r.dest_rank = folded;
          else r.dest_null = 1'b1;
          c[dir] = c[dir] - 2 * longint'(displ);
          if (fold_coords_to_rank(c, folded)) r.source_rank = folded;
          else r.source_null = 1'b1;
        end
      end
      default: begin
        r.status = ST_BADARG;
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    map_result_t got;
    map_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = map_result_t'(out_tdata[$bits(map_result_t)-1:0]);
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result transaction with no prediction pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, got.status);
        check_field("rank_out", want.rank_out, got.rank_out);
        check_field("rank_null", want.rank_null, got.rank_null);
        for (int d = 0; d < 4; d++)
          check_field($sformatf("coord_out_%0d", d), want.coord[d], got.coord[d]);
        check_field("source_rank", want.source_rank, got.source_rank);
        check_field("source_null", want.source_null, got.source_null);
        check_field("dest_rank", want.dest_rank, got.dest_rank);
        check_field("dest_null", want.dest_null, got.dest_null);
      end
    end
  end

  // Receiver backpressure: mostly ready, short stalls, now and then a long one.
  always @(negedge clk) begin
    int r;
    if (no_idle) begin
      out_tready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready = 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_tready = 1'b1;
      end else begin
        stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        out_tready = 1'b0;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Send one query transaction and record its predicted result on acceptance.
  task automatic send_query(crcm_op_t op, logic [RANK_W-1:0] rank,
                            logic signed [COORD_W-1:0] cin[4],
                            logic [DIR_W-1:0] dir, logic signed [DISPL_W-1:0] displ);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = {4'b0, displ, dir, cin[3], cin[2], cin[1], cin[0], rank};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_mapping(op, rank, cin, dir, displ));
    items_sent++;
  endtask

  // Stop sending and wait for every prediction to be matched.
  task automatic drain_pipeline();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [EXT_W-1:0] value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_addr = idx;
    cfg_wr_data = value;
    @(posedge clk);
    case (idx)
      CFG_NUM_DIMS:   grid_dims = value[2:0];
      CFG_DIM_SIZE_0: grid_ext[0] = value;
      CFG_DIM_SIZE_1: grid_ext[1] = value;
      CFG_DIM_SIZE_2: grid_ext[2] = value;
      CFG_DIM_SIZE_3: grid_ext[3] = value;
      CFG_PERIODIC:   grid_wrap = value[3:0];
      CFG_NODE_COUNT: grid_nodes = value;
      default: ;
    endcase
  endtask

  task automatic set_grid(logic [2:0] dims, logic [EXT_W-1:0] e0, logic [EXT_W-1:0] e1,
                          logic [EXT_W-1:0] e2, logic [EXT_W-1:0] e3,
                          logic [3:0] wrap, logic [EXT_W-1:0] nodes);
    drain_pipeline();
    write_reg(CFG_NUM_DIMS, dims);
    write_reg(CFG_DIM_SIZE_0, e0);
    write_reg(CFG_DIM_SIZE_1, e1);
    write_reg(CFG_DIM_SIZE_2, e2);
    write_reg(CFG_DIM_SIZE_3, e3);
    write_reg(CFG_PERIODIC, wrap);
    write_reg(CFG_NODE_COUNT, nodes);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    config_phases++;
  endtask

  // Coordinate near or inside the extent, or anywhere in the field.
  function automatic logic signed [COORD_W-1:0] pick_coord(logic [EXT_W-1:0] ext);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70 && ext != 0) return COORD_W'($urandom_range(0, ext - 1));
    if (r < 85) return COORD_W'(longint'(ext) + $urandom_range(0, 4) - 2);
    if (r < 90) return -COORD_W'($urandom_range(1, 3));
    return COORD_W'($urandom);
  endfunction

  task automatic send_random_query();
    crcm_op_t op;
    logic [RANK_W-1:0] rank;
    logic signed [COORD_W-1:0] cin[4];
    logic [DIR_W-1:0] dir;
    logic signed [DISPL_W-1:0] displ;
    int r;
    int n;
    n = used_dim_count();
    r = $urandom_range(0, 99);
    op = (r < 30) ? OP_SPLIT : (r < 60) ? OP_FOLD : (r < 96) ? OP_SHIFT : OP_RSVD;
    if ($urandom_range(0, 9) < 7 && grid_nodes != 0)
      rank = RANK_W'($urandom_range(0, grid_nodes - 1));
    else
      rank = RANK_W'($urandom);
    for (int d = 0; d < 4; d++) cin[d] = pick_coord(grid_ext[d]);
    if ($urandom_range(0, 99) < 85 && n > 0) dir = DIR_W'($urandom_range(0, n - 1));
    else dir = DIR_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 5) displ = '0;
    else if (r < 80) displ = DISPL_W'($urandom_range(1, 6)) * ($urandom_range(0, 1) ? 1 : -1);
    else if (r < 90 && n > 0 && int'(dir) < n)
      displ = DISPL_W'($urandom_range(1, grid_ext[dir] + 1)) * ($urandom_range(0, 1) ? 1 : -1);
    else displ = DISPL_W'($urandom);
    send_query(op, rank, cin, dir, displ);
  endtask

  // Queries against the reset configuration: one dimension of extent one.
  task automatic test_reset_grid();
    logic signed [COORD_W-1:0] cin[4];
    cin = '{0, 5, -1, 7};
    send_query(OP_SPLIT, 20'hFFFFF, cin, 3'd0, 21'sd1);
    send_query(OP_FOLD, 20'd0, cin, 3'd0, 21'sd1);
    cin[0] = 22'sd1;
    send_query(OP_FOLD, 20'd0, cin, 3'd0, 21'sd1);
    send_query(OP_SHIFT, 20'd0, cin, 3'd0, 21'sd1);
    send_query(OP_SHIFT, 20'd0, cin, 3'd1, 21'sd1);
  endtask

  // Field extremes, every op and each corner case on a mixed 2x3x4x5 grid.
  task automatic test_directed_cases();
    logic signed [COORD_W-1:0] cin[4];
    set_grid(3'd4, 21'd2, 21'd3, 21'd4, 21'd5, 4'b0101, 21'd120);
    write_reg(CFG_UNMAPPED, 21'h1FFFFF);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    drain_pipeline();
    cin = '{1, 2, 3, 4};
    send_query(OP_SPLIT, 20'd0, cin, 3'd0, 21'sd1);
    send_query(OP_SPLIT, 20'd119, cin, 3'd0, 21'sd1);
    send_query(OP_SPLIT, 20'hFFFFF, cin, 3'd0, 21'sd1);
    send_query(OP_FOLD, 20'd0, cin, 3'd0, 21'sd1);
    cin = '{-1, 0, 0, 0};
    send_query(OP_FOLD, 20'd0, cin, 3'd0, 21'sd1);
    cin = '{0, 3, 0, 0};
    send_query(OP_FOLD, 20'd0, cin, 3'd0, 21'sd1);
    cin = '{1, 2, -5, 0};
    send_query(OP_FOLD, 20'd0, cin, 3'd0, 21'sd1);
    cin = '{22'sh1FFFFF, 0, 22'sh1FFFFF, 0};
    send_query(OP_FOLD, 20'd0, cin, 3'd0, 21'sd1);
    cin = '{22'sh200000, 1, 22'sh200000, 22'sh3FFFFF};
    send_query(OP_FOLD, 20'd0, cin, 3'd0, 21'sd1);
    send_query(OP_SHIFT, 20'd37, cin, 3'd3, 21'sd1);
    send_query(OP_SHIFT, 20'd0, cin, 3'd3, -21'sd1);
    send_query(OP_SHIFT, 20'd0, cin, 3'd0, 21'sd1);
    send_query(OP_SHIFT, 20'd119, cin, 3'd2, 21'sd7);
    send_query(OP_SHIFT, 20'd50, cin, 3'd1, 21'sd0);
    send_query(OP_SHIFT, 20'd50, cin, 3'd5, 21'sd1);
    send_query(OP_SHIFT, 20'd50, cin, 3'd7, 21'sd1);
    send_query(OP_SHIFT, 20'hFFFFF, cin, 3'd2, 21'sh0FFFFF);
    send_query(OP_SHIFT, 20'd1, cin, 3'd0, 21'sh100000);
    send_query(OP_RSVD, 20'hFFFFF, cin, 3'd7, 21'sh1FFFFF);
  endtask

  // Two back-to-back bursts with the receiver always ready, drained in between.
  task automatic test_pressure();
    no_idle = 1'b1;
    repeat (20) send_random_query();
    drain_pipeline();
    repeat (20) send_random_query();
    no_idle = 1'b0;
  endtask

  // Random queries over a sequence of grid settings, extremes included.
  task automatic test_random_grids();
    int per_phase;
    logic [EXT_W-1:0] e[4];
    per_phase = RANDOM_ITEMS / 14;
    for (int p = 0; p < 14; p++) begin
      case (p)
        0: set_grid(3'd4, 21'd2, 21'd3, 21'd4, 21'd5, 4'b0101, 21'd120);
        1: set_grid(3'd3, 21'd8, 21'd16, 21'd4, 21'd1, 4'b0111, 21'd512);
        2: set_grid(3'd2, 21'd1024, 21'd1024, 21'd1, 21'd1, 4'b0001, 21'd1048576);
        3: set_grid(3'd1, 21'd1048576, 21'd1, 21'd1, 21'd1, 4'b0001, 21'd1048576);
        4: set_grid(3'd4, 21'd7, 21'd1, 21'd9, 21'd3, 4'b1111, 21'd189);
        5: set_grid(3'd0, 21'd5, 21'd5, 21'd5, 21'd5, 4'b1111, 21'd1);
        6: set_grid(3'd7, 21'd3, 21'd3, 21'd3, 21'd3, 4'b1010, 21'd81);
        7: set_grid(3'd4, 21'd2, 21'd0, 21'd5, 21'h1FFFFF, 4'b0010, 21'd100);
        8: set_grid(3'd4, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 4'b1111,
                    21'h1FFFFF);
        9: set_grid(3'd2, 21'd0, 21'd6, 21'd1, 21'd1, 4'b0001, 21'd0);
        default: begin
          for (int d = 0; d < 4; d++) e[d] = $urandom_range(1, 16);
          set_grid(3'($urandom_range(1, 4)), e[0], e[1], e[2], e[3], 4'($urandom),
                   ($urandom_range(0, 3) == 0) ? 21'($urandom)
                                               : 21'(e[0] * e[1] * e[2] * e[3]));
        end
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (per_phase) send_random_query();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    grid_dims = 3'd1;
    grid_ext = '{21'd1, 21'd1, 21'd1, 21'd1};
    grid_wrap = 4'b0;
    grid_nodes = 21'd1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_grid();
    test_directed_cases();
    test_pressure();
    test_random_grids();
    drain_pipeline();
    $display("Covered %0d query transactions and %0d results over %0d grid settings,",
             items_sent, results_seen, config_phases);
    $display("all three ops plus the reserved code, with wrap, null and overflow cases.");
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/crcm_pkg.sv
hw/rtl/crcm_div_pipe.sv
hw/rtl/cartesian_rank_coordinate_map_unit.sv
hw/rtl/crcm_checker.sv
sim/tb_cartesian_rank_coordinate_map_unit.sv
